/* hw/rtl/rmpt_pkg.sv */
// ----------------------------------------------------------------------------
// rmpt_pkg
// Shared types, constants and helpers of the range matrix product tree.
// ----------------------------------------------------------------------------
package rmpt_pkg;

  // Prime modulus and Barrett constant floor(2^60 / P)
  localparam logic [29:0] P_MOD      = 30'd1000000007;
  localparam logic [31:0] P_MOD_X2   = 32'd2000000014;
  localparam logic [30:0] BARRETT_MU = 31'd1152921496;

  // Tree geometry: perfect heap, node 1 is the root, leaves at MAX_LEAVES..
  localparam int unsigned MAX_LEAVES = 1024;
  localparam int unsigned NODE_AW    = $clog2(2 * MAX_LEAVES);
  localparam int unsigned PTR_W      = NODE_AW + 1;
  localparam int unsigned POS_W      = 11;
  localparam int unsigned ELEM_W     = 30;

  // Command kinds and register indexes
  localparam logic CMD_QUERY  = 1'b0;
  localparam logic CMD_TOGGLE = 1'b1;
  localparam logic REG_LEAF_COUNT = 1'b0;

  typedef logic [ELEM_W-1:0] elem_t;
  typedef elem_t [3:0]       mat_t;   // entry index row*2+col

  localparam mat_t MAT_ONES  = {4{30'd1}};
  localparam mat_t MAT_IDENT = {30'd1, 30'd0, 30'd0, 30'd1};

  // Node memory read address source
  typedef enum logic [2:0] {
    RA_X, RA_X2, RA_X2P1, RA_L, RA_R
  } rsel_e;

  // Node memory write data source
  typedef enum logic [1:0] {
    W_ONES, W_MM, W_FLIP
  } wsel_e;

  // Node pointer operation
  typedef enum logic [2:0] {
    X_HOLD, X_INC, X_DEC, X_HALF, X_POS, X_LEAF_TOP
  } xop_e;

  // Controller to datapath commands
  typedef struct packed {
    logic  item_ld;
    rsel_e rsel;
    logic  ld_a;
    logic  a_from_res;
    logic  ld_b;
    logic  b_from_res;
    logic  mm_start;
    logic  wr;
    wsel_e wsel;
    xop_e  xop;
    logic  q_init;
    logic  l_inc;
    logic  r_dec;
    logic  lr_half;
    logic  resl_ld;
    logic  resr_ld;
    logic  out_ld;
    logic  out_err;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_toggle;
    logic tog_ok;
    logic qry_ok;
    logic x_last_leaf;
    logic x_root;
    logic l_gt_r;
    logic l_odd;
    logic r_even;
    logic mm_busy;
    logic out_free;
  } dp_stat_t;

  // Sum of two residues, reduced
  function automatic elem_t mod_add(elem_t a, elem_t b);
    logic [ELEM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, P_MOD}) begin
      s = s - {1'b0, P_MOD};
    end
    return s[ELEM_W-1:0];
  endfunction

endpackage

/* hw/rtl/rmpt_modmul.sv */
// ----------------------------------------------------------------------------
// rmpt_modmul
// Four-stage pipelined modular multiplier, Barrett reduction by P_MOD.
// ----------------------------------------------------------------------------
module rmpt_modmul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [2:0]          in_tag_i,
  input  rmpt_pkg::elem_t     a_i,
  input  rmpt_pkg::elem_t     b_i,
  output logic                out_valid_o,
  output logic [2:0]          out_tag_o,
  output rmpt_pkg::elem_t     out_o
);
  import rmpt_pkg::*;

  logic [59:0] prod_q;
  logic [30:0] quo_q;
  logic [31:0] lo1_q, rem_q;
  elem_t       res_q;
  logic [61:0] qm;
  logic [60:0] qp;
  logic [31:0] rem_d;
  elem_t       res_d;
  logic [3:0]  vld_q;
  logic [2:0]  tag_q [4];

  // Quotient estimate and remainder
  assign qm    = 62'(prod_q[59:29]) * 62'(BARRETT_MU);
  assign qp    = 61'(quo_q) * 61'(P_MOD);
  assign rem_d = lo1_q - qp[31:0];

  // Final correction, remainder below three times the modulus
  always_comb begin
    if (rem_q >= P_MOD_X2) begin
      res_d = ELEM_W'(rem_q - P_MOD_X2);
    end else if (rem_q >= {2'b0, P_MOD}) begin
      res_d = ELEM_W'(rem_q - {2'b0, P_MOD});
    end else begin
      res_d = rem_q[ELEM_W-1:0];
    end
  end

  // Data stages
  always_ff @(posedge clk_i) begin
    prod_q <= 60'(a_i) * 60'(b_i);
    quo_q  <= qm[61:31];
    lo1_q  <= prod_q[31:0];
    rem_q  <= rem_d;
    res_q  <= res_d;
    tag_q[0] <= in_tag_i;
    tag_q[1] <= tag_q[0];
    tag_q[2] <= tag_q[1];
    tag_q[3] <= tag_q[2];
  end

  // Valid pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[3];
  assign out_tag_o   = tag_q[3];
  assign out_o       = res_q;

endmodule

/* hw/rtl/rmpt_matmul.sv */
// ----------------------------------------------------------------------------
// rmpt_matmul
// 2x2 modular matrix product: eight products through one shared multiplier.
// ----------------------------------------------------------------------------
module rmpt_matmul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  rmpt_pkg::mat_t     a_i,
  input  rmpt_pkg::mat_t     b_i,
  output logic               busy_o,
  output rmpt_pkg::mat_t     c_o
);
  import rmpt_pkg::*;

  logic       issuing_q, busy_q;
  logic [2:0] k_q;
  elem_t      mul_a, mul_b, mul_r, hold_q;
  logic       mul_v;
  logic [2:0] mul_tag;
  mat_t       c_q;

  // Product k: row k[2], column k[1], inner index k[0]
  assign mul_a = a_i[{k_q[2], k_q[0]}];
  assign mul_b = b_i[{k_q[0], k_q[1]}];

  rmpt_modmul u_modmul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (issuing_q),
    .in_tag_i    (k_q),
    .a_i         (mul_a),
    .b_i         (mul_b),
    .out_valid_o (mul_v),
    .out_tag_o   (mul_tag),
    .out_o       (mul_r)
  );

  // Issue sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issuing_q <= 1'b0;
      busy_q    <= 1'b0;
      k_q       <= '0;
    end else begin
      if (start_i) begin
        issuing_q <= 1'b1;
        busy_q    <= 1'b1;
        k_q       <= '0;
      end else if (issuing_q) begin
        k_q <= k_q + 3'd1;
        if (k_q == 3'd7) begin
          issuing_q <= 1'b0;
        end
      end
      if (mul_v && mul_tag == 3'd7) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Pairwise accumulation into the result entries
  always_ff @(posedge clk_i) begin
    if (mul_v) begin
      if (!mul_tag[0]) begin
        hold_q <= mul_r;
      end else begin
        c_q[mul_tag[2:1]] <= mod_add(hold_q, mul_r);
      end
    end
  end

  assign busy_o = busy_q;
  assign c_o    = c_q;

endmodule

/* hw/rtl/rmpt_datapath.sv */
// ----------------------------------------------------------------------------
// rmpt_datapath
// Node memory, pointers, partial products and the result register.
// ----------------------------------------------------------------------------
module rmpt_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rmpt_pkg::dp_cmd_t            cmd_i,
  output rmpt_pkg::dp_stat_t           stat_o,
  input  logic [rmpt_pkg::POS_W-1:0]   leaf_count_i,
  // in: item fields
  input  logic                         in_cmd_i,
  input  logic [rmpt_pkg::POS_W-1:0]   in_first_i,
  input  logic [rmpt_pkg::POS_W-1:0]   in_last_i,
  input  logic                         in_row_i,
  input  logic                         in_col_i,
  // out: result
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [rmpt_pkg::ELEM_W-1:0]  out_count_o,
  output logic                         out_error_o
);
  import rmpt_pkg::*;

  localparam logic [PTR_W-1:0] LEAF_TOP = PTR_W'(MAX_LEAVES - 1);

  mat_t              node_mem [2**NODE_AW];
  mat_t              rdata_q, wdata, a_q, b_q, mm_c, resl_q, resr_q, flip;
  logic [NODE_AW-1:0] raddr;
  logic [PTR_W-1:0]  x_q, l_q, r_q;
  logic              cmd_q, row_q, col_q;
  logic [POS_W-1:0]  first_q, last_q, limit;
  logic              out_valid_q, out_error_q;
  elem_t             out_count_q;
  logic [31:0]       sum0, sum1;
  elem_t             sum2;

  // Leaves in use
  assign limit = (leaf_count_i < POS_W'(MAX_LEAVES)) ? leaf_count_i : POS_W'(MAX_LEAVES);

  // Item latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.item_ld) begin
      cmd_q   <= in_cmd_i;
      first_q <= in_first_i;
      last_q  <= in_last_i;
      row_q   <= in_row_i;
      col_q   <= in_col_i;
    end
  end

  // Read address
  always_comb begin
    case (cmd_i.rsel)
      RA_X:    raddr = x_q[NODE_AW-1:0];
      RA_X2:   raddr = {x_q[NODE_AW-2:0], 1'b0};
      RA_X2P1: raddr = {x_q[NODE_AW-2:0], 1'b1};
      RA_L:    raddr = l_q[NODE_AW-1:0];
      RA_R:    raddr = r_q[NODE_AW-1:0];
      default: raddr = x_q[NODE_AW-1:0];
    endcase
  end

  // Leaf entry flip
  always_comb begin
    flip = rdata_q;
    flip[{row_q, col_q}] = {{(ELEM_W-1){1'b0}}, ~rdata_q[{row_q, col_q}][0]};
  end

  always_comb begin
    case (cmd_i.wsel)
      W_ONES:  wdata = MAT_ONES;
      W_MM:    wdata = mm_c;
      W_FLIP:  wdata = flip;
      default: wdata = MAT_ONES;
    endcase
  end

  // Node memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      node_mem[x_q[NODE_AW-1:0]] <= wdata;
    end
    rdata_q <= node_mem[raddr];
  end

  // Matrix product operands and partial products
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_a) begin
      a_q <= cmd_i.a_from_res ? resl_q : rdata_q;
    end
    if (cmd_i.ld_b) begin
      b_q <= cmd_i.b_from_res ? resr_q : rdata_q;
    end
    if (cmd_i.q_init) begin
      resl_q <= MAT_IDENT;
      resr_q <= MAT_IDENT;
    end else begin
      if (cmd_i.resl_ld) begin
        resl_q <= mm_c;
      end
      if (cmd_i.resr_ld) begin
        resr_q <= mm_c;
      end
    end
  end

  rmpt_matmul u_matmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mm_start),
    .a_i     (a_q),
    .b_i     (b_q),
    .busy_o  (stat_o.mm_busy),
    .c_o     (mm_c)
  );

  // Node and range pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= PTR_W'(MAX_LEAVES);
      l_q <= '0;
      r_q <= '0;
    end else begin
      case (cmd_i.xop)
        X_HOLD:     x_q <= x_q;
        X_INC:      x_q <= x_q + 1'b1;
        X_DEC:      x_q <= x_q - 1'b1;
        X_HALF:     x_q <= x_q >> 1;
        X_POS:      x_q <= LEAF_TOP + PTR_W'(first_q);
        X_LEAF_TOP: x_q <= LEAF_TOP;
        default:    x_q <= x_q;
      endcase
      if (cmd_i.q_init) begin
        l_q <= LEAF_TOP + PTR_W'(first_q);
        r_q <= LEAF_TOP + PTR_W'(last_q);
      end else if (cmd_i.lr_half) begin
        l_q <= l_q >> 1;
        r_q <= r_q >> 1;
      end else begin
        if (cmd_i.l_inc) begin
          l_q <= l_q + 1'b1;
        end
        if (cmd_i.r_dec) begin
          r_q <= r_q - 1'b1;
        end
      end
    end
  end

  // Entry sum reduced below the modulus
  assign sum0 = 32'(mm_c[0]) + 32'(mm_c[1]) + 32'(mm_c[2]) + 32'(mm_c[3]);
  assign sum1 = (sum0 >= P_MOD_X2) ? sum0 - P_MOD_X2 : sum0;
  assign sum2 = (sum1 >= {2'b0, P_MOD}) ? ELEM_W'(sum1 - {2'b0, P_MOD}) : sum1[ELEM_W-1:0];

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld || cmd_i.out_err) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_count_q <= sum2;
      out_error_q <= 1'b0;
    end else if (cmd_i.out_err) begin
      out_count_q <= '0;
      out_error_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_count_o = out_count_q;
  assign out_error_o = out_error_q;

  // Status
  assign stat_o.is_toggle   = (cmd_q == CMD_TOGGLE);
  assign stat_o.tog_ok      = (first_q != '0) && (first_q <= limit);
  assign stat_o.qry_ok      = (first_q != '0) && (last_q >= first_q) && (last_q <= limit);
  assign stat_o.x_last_leaf = (x_q == PTR_W'(2 * MAX_LEAVES - 1));
  assign stat_o.x_root      = (x_q == PTR_W'(1));
  assign stat_o.l_gt_r      = (l_q > r_q);
  assign stat_o.l_odd       = l_q[0];
  assign stat_o.r_even      = ~r_q[0];
  assign stat_o.out_free    = ~out_valid_q | out_ready_i;

endmodule

/* hw/rtl/rmpt_ctrl.sv */
// ----------------------------------------------------------------------------
// rmpt_ctrl
// Sequencer: tree build after reset, leaf toggle with path refresh, range query.
// ----------------------------------------------------------------------------
module rmpt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rmpt_pkg::dp_stat_t   stat_i,
  output rmpt_pkg::dp_cmd_t    cmd_o
);
  import rmpt_pkg::*;

  localparam logic [4:0] ST_FILL    = 5'd0;
  localparam logic [4:0] ST_IDLE    = 5'd1;
  localparam logic [4:0] ST_DEC     = 5'd2;
  localparam logic [4:0] ST_TG_RD   = 5'd3;
  localparam logic [4:0] ST_TG_WR   = 5'd4;
  localparam logic [4:0] ST_RB_RD0  = 5'd5;
  localparam logic [4:0] ST_RB_RD1  = 5'd6;
  localparam logic [4:0] ST_RB_MUL  = 5'd7;
  localparam logic [4:0] ST_RB_WAIT = 5'd8;
  localparam logic [4:0] ST_Q_CHK   = 5'd9;
  localparam logic [4:0] ST_Q_LMUL  = 5'd10;
  localparam logic [4:0] ST_Q_LWAIT = 5'd11;
  localparam logic [4:0] ST_Q_RCHK  = 5'd12;
  localparam logic [4:0] ST_Q_RMUL  = 5'd13;
  localparam logic [4:0] ST_Q_RWAIT = 5'd14;
  localparam logic [4:0] ST_Q_SH    = 5'd15;
  localparam logic [4:0] ST_Q_FIN   = 5'd16;
  localparam logic [4:0] ST_Q_FWAIT = 5'd17;
  localparam logic [4:0] ST_Q_ERR   = 5'd18;

  localparam logic MODE_BUILD  = 1'b0;
  localparam logic MODE_TOGGLE = 1'b1;

  logic [4:0] state_q, state_d;
  logic       mode_q, mode_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      mode_q  <= MODE_BUILD;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and command decode
  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    cmd_o   = '0;
    cmd_o.rsel = RA_X;
    cmd_o.wsel = W_ONES;
    cmd_o.xop  = X_HOLD;
    case (state_q)
      // Leaves to all-ones, then build upwards
      ST_FILL: begin
        cmd_o.wr = 1'b1;
        if (stat_i.x_last_leaf) begin
          cmd_o.xop = X_LEAF_TOP;
          mode_d    = MODE_BUILD;
          state_d   = ST_RB_RD0;
        end else begin
          cmd_o.xop = X_INC;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.item_ld = 1'b1;
          state_d       = ST_DEC;
        end
      end
      ST_DEC: begin
        if (stat_i.is_toggle) begin
          if (stat_i.tog_ok) begin
            cmd_o.xop = X_POS;
            state_d   = ST_TG_RD;
          end else begin
            state_d = ST_IDLE;
          end
        end else if (stat_i.qry_ok) begin
          cmd_o.q_init = 1'b1;
          state_d      = ST_Q_CHK;
        end else begin
          state_d = ST_Q_ERR;
        end
      end
      // Toggle: flip the leaf, then refresh its ancestors
      ST_TG_RD: begin
        cmd_o.rsel = RA_X;
        state_d    = ST_TG_WR;
      end
      ST_TG_WR: begin
        cmd_o.wr   = 1'b1;
        cmd_o.wsel = W_FLIP;
        cmd_o.xop  = X_HALF;
        mode_d     = MODE_TOGGLE;
        state_d    = ST_RB_RD0;
      end
      // Node refresh from its two children
      ST_RB_RD0: begin
        cmd_o.rsel = RA_X2;
        state_d    = ST_RB_RD1;
      end
      ST_RB_RD1: begin
        cmd_o.ld_a = 1'b1;
        cmd_o.rsel = RA_X2P1;
        state_d    = ST_RB_MUL;
      end
      ST_RB_MUL: begin
        cmd_o.ld_b     = 1'b1;
        cmd_o.mm_start = 1'b1;
        state_d        = ST_RB_WAIT;
      end
      ST_RB_WAIT: begin
        if (!stat_i.mm_busy) begin
          cmd_o.wr   = 1'b1;
          cmd_o.wsel = W_MM;
          if (stat_i.x_root) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.xop = (mode_q == MODE_BUILD) ? X_DEC : X_HALF;
            state_d   = ST_RB_RD0;
          end
        end
      end
      // Query: bottom-up walk with left and right partial products
      ST_Q_CHK: begin
        cmd_o.rsel = RA_L;
        if (stat_i.l_gt_r) begin
          state_d = ST_Q_FIN;
        end else if (stat_i.l_odd) begin
          state_d = ST_Q_LMUL;
        end else begin
          state_d = ST_Q_RCHK;
        end
      end
      ST_Q_LMUL: begin
        cmd_o.ld_a       = 1'b1;
        cmd_o.a_from_res = 1'b1;
        cmd_o.ld_b       = 1'b1;
        cmd_o.mm_start   = 1'b1;
        state_d          = ST_Q_LWAIT;
      end
      ST_Q_LWAIT: begin
        if (!stat_i.mm_busy) begin
          cmd_o.resl_ld = 1'b1;
          cmd_o.l_inc   = 1'b1;
          state_d       = ST_Q_RCHK;
        end
      end
      ST_Q_RCHK: begin
        cmd_o.rsel = RA_R;
        state_d    = stat_i.r_even ? ST_Q_RMUL : ST_Q_SH;
      end
      ST_Q_RMUL: begin
        cmd_o.ld_a       = 1'b1;
        cmd_o.ld_b       = 1'b1;
        cmd_o.b_from_res = 1'b1;
        cmd_o.mm_start   = 1'b1;
        state_d          = ST_Q_RWAIT;
      end
      ST_Q_RWAIT: begin
        if (!stat_i.mm_busy) begin
          cmd_o.resr_ld = 1'b1;
          cmd_o.r_dec   = 1'b1;
          state_d       = ST_Q_SH;
        end
      end
      ST_Q_SH: begin
        cmd_o.lr_half = 1'b1;
        state_d       = ST_Q_CHK;
      end
      ST_Q_FIN: begin
        cmd_o.ld_a       = 1'b1;
        cmd_o.a_from_res = 1'b1;
        cmd_o.ld_b       = 1'b1;
        cmd_o.b_from_res = 1'b1;
        cmd_o.mm_start   = 1'b1;
        state_d          = ST_Q_FWAIT;
      end
      ST_Q_FWAIT: begin
        if (!stat_i.mm_busy && stat_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_Q_ERR: begin
        if (stat_i.out_free) begin
          cmd_o.out_err = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/range_matrix_product_mod_tree_top.sv */
// ----------------------------------------------------------------------------
// range_matrix_product_mod_tree_top
// Segment tree of 2x2 0/1 matrices with range products modulo 1000000007.
// ----------------------------------------------------------------------------
// One item at a time. After reset the block fills the 1024 leaves and
// builds the tree with the input not ready. A matrix product runs eight
// modular multiplies through one pipelined multiplier. A toggle runs one
// product per tree level; a query runs up to two products per level,
// depending on the range, plus a final product; a rejected query waits
// while an earlier result still waits. Results are held in an output
// register, so an input transfer may be taken while a result waits.
// The leaf_count register sits at byte address 0 and may be written at
// any time the block is idle.
// ----------------------------------------------------------------------------
module range_matrix_product_mod_tree_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o,
  // Input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // position[10:0], last_position[21:11],
                                        // entry_row[22], entry_col[23]
  input  logic        s_axis_tuser_i,   // cmd[0]
  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // path_count[29:0], zero[31:30]
  output logic        m_axis_tuser_o    // range_error[0]
);
  import rmpt_pkg::*;

  logic [POS_W-1:0] leaf_count_q;
  dp_cmd_t          dp_cmd;
  dp_stat_t         dp_stat;
  elem_t            out_count;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaf_count_q <= POS_W'(1024);
    end else if (psel_i && penable_i && pwrite_i && paddr_i[2] == REG_LEAF_COUNT) begin
      leaf_count_q <= pwdata_i[POS_W-1:0];
    end
  end

  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == REG_LEAF_COUNT) ? 32'(leaf_count_q) : '0;

  rmpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  rmpt_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .leaf_count_i (leaf_count_q),
    .in_cmd_i     (s_axis_tuser_i),
    .in_first_i   (s_axis_tdata_i[10:0]),
    .in_last_i    (s_axis_tdata_i[21:11]),
    .in_row_i     (s_axis_tdata_i[22]),
    .in_col_i     (s_axis_tdata_i[23]),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_count_o  (out_count),
    .out_error_o  (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {2'b00, out_count};

endmodule

/* hw/rtl/rmpt_checker.sv */
// ----------------------------------------------------------------------------
// rmpt_checker
// Port-level checks of the range matrix product tree, bound to the top level.
// ----------------------------------------------------------------------------
module rmpt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);
  import rmpt_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // Rejected queries carry a zero count
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("error result with non-zero count");

  // Count is a reduced residue
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o < 32'(P_MOD))
    else $error("count not reduced");

  // Configuration port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready_o)
    else $error("pready low");

endmodule

bind range_matrix_product_mod_tree_top rmpt_checker u_rmpt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .pready_o        (pready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the range matrix product tree. Toggle and query
// commands go in over the input stream. A bit-level predictor holds the
// leaf matrices and works out each range product modulo the prime. Every
// result transfer is compared field by field, in order, with the
// predicted value. Phases vary leaf_count over the APB port and apply
// different amounts of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rmpt_pkg::*;

  localparam longint unsigned PRIME = 64'd1000000007;

  typedef struct {
    logic [29:0] path_count;
    logic        range_error;
  } tree_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel_i;
  logic        penable_i;
  logic        pwrite_i;
  logic [2:0]  paddr_i;
  logic [31:0] pwdata_i;
  logic [31:0] prdata_o;
  logic        pready_o;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i;   // position[10:0], last_position[21:11],
                                 // entry_row[22], entry_col[23]
  logic        s_axis_tuser_i;   // cmd[0]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;   // path_count[29:0], zero[31:30]
  logic        m_axis_tuser_o;   // range_error[0]

  // Predictor state
  logic [3:0]   leaf_mirror [MAX_LEAVES];
  logic [10:0]  leaf_count_mirror;
  tree_result_t pending_counts [$];

  int error_count;
  int send_idle_pct;
  int recv_stall_pct;

  range_matrix_product_mod_tree_top uut (.*);

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #60ms;
    $display("== FAIL ==");
    $finish;
  end

  // Result receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checker
  always @(posedge clk_i) begin
    tree_result_t exp_r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_counts.size() == 0) begin
        $display("%0t unexpected result: count %0d err %0b", $time,
                 m_axis_tdata_o[29:0], m_axis_tuser_o);
        error_count++;
      end else begin
        exp_r = pending_counts.pop_front();
        if (m_axis_tdata_o[29:0] !== exp_r.path_count) begin
          $display("%0t path_count mismatch: expected %0d actual %0d", $time,
                   exp_r.path_count, m_axis_tdata_o[29:0]);
          error_count++;
        end
        if (m_axis_tuser_o !== exp_r.range_error) begin
          $display("%0t range_error mismatch: expected %0b actual %0b", $time,
                   exp_r.range_error, m_axis_tuser_o);
          error_count++;
        end
        if (m_axis_tdata_o[31:30] !== 2'b00) begin
          $display("%0t pad bits mismatch: expected 0 actual %0d", $time,
                   m_axis_tdata_o[31:30]);
          error_count++;
        end
      end
    end
  end

  // Modular 2x2 product, entry index row*2+col
  function automatic mat_t mat_mul_mod(mat_t a, mat_t b);
    mat_t c;
    longint unsigned s;
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        s = (longint'(a[i*2]) * longint'(b[j])) % PRIME;
        s += (longint'(a[i*2+1]) * longint'(b[2+j])) % PRIME;
        c[i*2+j] = elem_t'(s % PRIME);
      end
    end
    return c;
  endfunction

  function automatic mat_t leaf_as_mat(int pos);
    mat_t m;
    for (int k = 0; k < 4; k++) m[k] = elem_t'(leaf_mirror[pos-1][k]);
    return m;
  endfunction

  // Apply one accepted command to the mirror and queue any result
  function automatic void predict_command(logic cmd, int pos, int last, logic row,
                                          logic col);
    int limit;
    mat_t prod;
    longint unsigned sum;
    tree_result_t r;
    limit = (leaf_count_mirror < MAX_LEAVES) ? leaf_count_mirror : MAX_LEAVES;
    if (cmd == CMD_TOGGLE) begin
      if (pos >= 1 && pos <= limit) leaf_mirror[pos-1][{row, col}] ^= 1'b1;
    end else if (pos < 1 || last < pos || last > limit) begin
      r.path_count = '0;
      r.range_error = 1'b1;
      pending_counts.push_back(r);
    end else begin
      prod = leaf_as_mat(pos);
      for (int p = pos + 1; p <= last; p++) prod = mat_mul_mod(prod, leaf_as_mat(p));
      sum = longint'(prod[0]) + prod[1] + prod[2] + prod[3];
      r.path_count = 30'(sum % PRIME);
      r.range_error = 1'b0;
      pending_counts.push_back(r);
    end
  endfunction

  // One command transfer, with random idle cycles ahead of it
  task automatic send_command(logic cmd, int pos, int last, logic row, logic col);
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {col, row, 11'(last), 11'(pos)};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_command(cmd, pos, last, row, col);
  endtask

  // Let the block go idle: results drained, then a wait that outlasts a toggle
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  // APB write of leaf_count: setup then access
  task automatic write_leaf_count(logic [10:0] value);
    @(negedge clk_i);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= 3'(4 * REG_LEAF_COUNT);
    pwdata_i  <= {$urandom_range(0, 1) ? 21'h1FFFFF : 21'h0, value};
    @(negedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    leaf_count_mirror = value;
    @(negedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
  endtask

  // Directed: extremes of the fields and the rejection cases
  task automatic test_directed();
    send_command(CMD_QUERY, 1, 1024, 0, 0);
    send_command(CMD_QUERY, 0, 5, 0, 0);
    send_command(CMD_QUERY, 9, 8, 1, 1);
    send_command(CMD_QUERY, 1, 1025, 0, 0);
    send_command(CMD_QUERY, 2047, 2047, 0, 0);
    send_command(CMD_QUERY, 1024, 1024, 0, 0);
    send_command(CMD_TOGGLE, 1, 0, 0, 0);
    send_command(CMD_TOGGLE, 1, 0, 0, 1);
    send_command(CMD_TOGGLE, 1, 0, 1, 0);
    send_command(CMD_TOGGLE, 1024, 2047, 1, 1);
    send_command(CMD_TOGGLE, 0, 3, 1, 1);
    send_command(CMD_TOGGLE, 1025, 0, 0, 0);
    send_command(CMD_TOGGLE, 2047, 0, 1, 1);
    send_command(CMD_QUERY, 1, 1, 0, 0);
    send_command(CMD_QUERY, 1, 2, 1, 1);
    send_command(CMD_QUERY, 1000, 1024, 0, 0);
    send_command(CMD_QUERY, 1, 1024, 1, 0);
    wait_idle();
    // zero leaf_count: every command rejected or ignored
    write_leaf_count(11'd0);
    send_command(CMD_QUERY, 1, 1, 0, 0);
    send_command(CMD_TOGGLE, 1, 0, 1, 1);
    send_command(CMD_QUERY, 0, 0, 0, 0);
    wait_idle();
    write_leaf_count(11'd1);
    send_command(CMD_QUERY, 1, 1, 0, 0);
    send_command(CMD_QUERY, 1, 2, 0, 0);
    send_command(CMD_TOGGLE, 2, 0, 0, 0);
    wait_idle();
  endtask

  // Random mix: mostly in-range toggles and queries, some noise
  task automatic test_random(logic [10:0] count_setting, int n_items);
    int limit;
    int pos;
    int last;
    int pick;
    write_leaf_count(count_setting);
    limit = (count_setting < MAX_LEAVES) ? count_setting : MAX_LEAVES;
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(99);
      if (pick < 10 || limit == 0) begin
        send_command(1'($urandom_range(1)), $urandom_range(2047), $urandom_range(2047),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
      end else if (pick < 55) begin
        send_command(CMD_TOGGLE, $urandom_range(1, limit), $urandom_range(2047),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        pos = $urandom_range(1, limit);
        if ($urandom_range(9) == 0) begin
          pos = $urandom_range(1, 3);
          last = limit;
        end else begin
          last = pos + $urandom_range(0, 20);
          if (last > limit) last = limit;
        end
        send_command(CMD_QUERY, pos, last, 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
    wait_idle();
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    rst_ni          = 1'b0;
    psel_i          = 1'b0;
    penable_i       = 1'b0;
    pwrite_i        = 1'b0;
    paddr_i         = '0;
    pwdata_i        = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    m_axis_tready_i = 1'b1;
    error_count     = 0;
    leaf_count_mirror = 11'd1024;
    for (int i = 0; i < MAX_LEAVES; i++) leaf_mirror[i] = 4'hF;
    set_idling(0, 0);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    set_idling(0, 0);
    test_random(11'd1024, 300);
    set_idling(61, 0);
    test_random(11'd37, 300);
    set_idling(0, 61);
    test_random(11'd2047, 300);
    set_idling(33, 33);
    test_random(11'd2, 250);
    set_idling(0, 0);
    test_random(11'($urandom_range(3, 1023)), 200);
    set_idling(33, 33);
    test_random(11'd1024, 200);

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
